/* src/assert_macros.svh */
// Assertion macros shared by the RTL files of the chroma key mask block.
// Needs a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is low.
`define CKBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion, checked during reset too.
`define CKBD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* src/ckbd_pkg.sv */
// Package of the chroma key box downsample mask: word types, register
// indexes, reset values and the state type. No dependencies.
`timescale 1ns / 1ps
package ckbd_pkg;

    localparam int MAX_EYE_WIDTH_DEF  = 2048;
    localparam int MAX_EYE_HEIGHT_DEF = 2048;
    localparam int MAX_MASK_WIDTH_DEF = 1024;

    localparam int TALLY_W = 23;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_U       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_V       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EYE_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EYE_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_HEIGHT = 3'd6;

    localparam logic [7:0]  RST_KEY_U       = 8'd54;
    localparam logic [7:0]  RST_KEY_V       = 8'd34;
    localparam logic [7:0]  RST_TOLERANCE   = 8'd34;
    localparam logic [11:0] RST_EYE_WIDTH   = 12'd640;
    localparam logic [11:0] RST_EYE_HEIGHT  = 12'd480;
    localparam logic [10:0] RST_MASK_WIDTH  = 11'd160;
    localparam logic [11:0] RST_MASK_HEIGHT = 12'd120;

    typedef struct packed {
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
        logic       eye_select;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic [7:0]  mask_value;
        logic [10:0] mask_column;
        logic [10:0] mask_row;
        logic        last_of_frame;
    } t_out;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_WGO,
        S_WWAIT,
        S_HGO,
        S_HWAIT,
        S_IDLE,
        S_READ,
        S_RMW,
        S_MUL,
        S_RWAIT,
        S_EMIT
    } t_state;

endpackage

/* src/ckbd_div.sv */
// Restoring divider, one quotient bit per cycle.
// Needs no package; depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ckbd_div #(
    parameter int NW = 32,
    parameter int DW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic [NW-1:0] o_quotient,
    output logic [DW-1:0] o_remainder,
    output logic          o_done
);
    localparam int CNT_W = $clog2(NW);

    logic [NW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DW:0]      trial;
    logic             fits;

    assign trial = {r_rem, r_quo[NW-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], fits};
            r_rem <= fits ? DW'(trial - {1'b0, r_dvs}) : DW'(trial);
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_done      = r_done;

    `CKBD_ASSERT(a_done_after_busy, o_done |-> $past(r_busy), "done without a running divide")
    `CKBD_ASSERT(a_busy_from_start, $rose(r_busy) |-> $past(i_start), "divide began unasked")
    `CKBD_ASSERT(a_done_single, o_done |=> !o_done, "done held two cycles")

endmodule

/* src/chroma_key_box_downsample_mask.sv */
// Top level of the chroma key box downsample mask.
// Depends on ckbd_pkg, ckbd_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//  Input channel (i_in_valid / o_in_stall / i_in_data) takes one word per
//  full-resolution pixel in raster order. Output channel (o_out_valid /
//  i_out_stall / o_out_data) gives one word per finished mask cell.
//  Config channel (i_cfg_valid / o_cfg_ready) writes one register per word;
//  it is always ready. Write it only while the block is idle.
//  Each pixel passes through accept, tally read and tally write back, set
//  by the single-port tally memory read-modify-write, with input stalled.
//  A pixel that closes a cell then goes through the multiply and the
//  bit-serial divide of the rounded share, and waits in the emit state
//  only if the previous word is still held. The output word sits in a
//  register, so the next pixel is accepted while the receiver stalls; a
//  second result waits until the first is taken. Reset, and any write to
//  a geometry register, run a clearing pass over all MAX_MASK_WIDTH tally
//  entries followed by two divides for the cell spacing; input stalls
//  meanwhile. A frame start in the middle of a frame also runs the
//  clearing pass before that pixel is counted. A normal frame end leaves
//  tallies at zero.
module chroma_key_box_downsample_mask #(
    parameter int MAX_EYE_WIDTH  = ckbd_pkg::MAX_EYE_WIDTH_DEF,
    parameter int MAX_EYE_HEIGHT = ckbd_pkg::MAX_EYE_HEIGHT_DEF,
    parameter int MAX_MASK_WIDTH = ckbd_pkg::MAX_MASK_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  ckbd_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ckbd_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ckbd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ckbd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ckbd_pkg::*;

    localparam int EW = $clog2(MAX_EYE_WIDTH + 1);
    localparam int EH = $clog2(MAX_EYE_HEIGHT + 1);
    localparam int MW = (MAX_MASK_WIDTH > 1) ? $clog2(MAX_MASK_WIDTH) : 1;
    localparam int SW = EW + EH;
    localparam int NW = TALLY_W + 9;
    localparam int CW = ((MW > EW) ? MW : EW) + 1;

    // ---------------- configuration registers
    logic [7:0]  r_key_u, r_key_v, r_tol;
    logic [11:0] r_eye_w, r_eye_h, r_mask_h;
    logic [10:0] r_mask_w;
    logic        cfg_acc, cfg_geom;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc  = i_cfg_valid;
    assign cfg_geom = cfg_acc && (i_cfg_index == REG_EYE_WIDTH ||
                      i_cfg_index == REG_EYE_HEIGHT || i_cfg_index == REG_MASK_WIDTH ||
                      i_cfg_index == REG_MASK_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_u  <= RST_KEY_U;
            r_key_v  <= RST_KEY_V;
            r_tol    <= RST_TOLERANCE;
            r_eye_w  <= RST_EYE_WIDTH;
            r_eye_h  <= RST_EYE_HEIGHT;
            r_mask_w <= RST_MASK_WIDTH;
            r_mask_h <= RST_MASK_HEIGHT;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                REG_KEY_U:       r_key_u  <= i_cfg_data[7:0];
                REG_KEY_V:       r_key_v  <= i_cfg_data[7:0];
                REG_TOLERANCE:   r_tol    <= i_cfg_data[7:0];
                REG_EYE_WIDTH:   r_eye_w  <= i_cfg_data;
                REG_EYE_HEIGHT:  r_eye_h  <= i_cfg_data;
                REG_MASK_WIDTH:  r_mask_w <= i_cfg_data[10:0];
                REG_MASK_HEIGHT: r_mask_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- effective geometry (clamped)
    logic [12:0] w13, h13, m_hi13, m13, n13;
    logic [EW-1:0] w_eff, m_eff;
    logic [EH-1:0] h_eff, n_eff;

    always_comb begin
        w13 = (r_eye_w == '0) ? 13'd1 :
              ({1'b0, r_eye_w} > 13'(MAX_EYE_WIDTH)) ? 13'(MAX_EYE_WIDTH) : {1'b0, r_eye_w};
        h13 = (r_eye_h == '0) ? 13'd1 :
              ({1'b0, r_eye_h} > 13'(MAX_EYE_HEIGHT)) ? 13'(MAX_EYE_HEIGHT) : {1'b0, r_eye_h};
        m_hi13 = (w13 < 13'(MAX_MASK_WIDTH)) ? w13 : 13'(MAX_MASK_WIDTH);
        m13 = (r_mask_w == '0) ? 13'd1 :
              ({2'b0, r_mask_w} > m_hi13) ? m_hi13 : {2'b0, r_mask_w};
        n13 = (r_mask_h == '0) ? 13'd1 :
              ({1'b0, r_mask_h} > h13) ? h13 : {1'b0, r_mask_h};
        w_eff = EW'(w13);
        h_eff = EH'(h13);
        m_eff = EW'(m13);
        n_eff = EH'(n13);
    end

    // ---------------- foreground test
    logic signed [8:0]  du, dv;
    logic signed [17:0] squ, sqv;
    logic [15:0]        tsq;
    logic               fg_in;

    always_comb begin
        du    = $signed({1'b0, i_in_data.chroma_u}) - $signed({1'b0, r_key_u});
        dv    = $signed({1'b0, i_in_data.chroma_v}) - $signed({1'b0, r_key_v});
        squ   = 18'(du) * 18'(du);
        sqv   = 18'(dv) * 18'(dv);
        tsq   = 16'(r_tol) * 16'(r_tol);
        fg_in = ({1'b0, squ[15:0]} + {1'b0, sqv[15:0]}) > {1'b0, tsq};
    end

    // ---------------- tally memory
    logic [TALLY_W-1:0] r_tally [MAX_MASK_WIDTH];
    logic [TALLY_W-1:0] r_rdata;
    logic               mem_we, mem_re;
    logic [MW-1:0]      mem_addr;
    logic [TALLY_W-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_tally[mem_addr] <= mem_wdata;
        if (mem_re) r_rdata <= r_tally[mem_addr];
    end

    // ---------------- divider
    logic          div_start, div_done;
    logic [NW-1:0] div_dividend, div_q;
    logic [SW-1:0] div_divisor, div_r;

    ckbd_div #(.NW(NW), .DW(SW)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_quotient  (div_q),
        .o_remainder (div_r),
        .o_done      (div_done)
    );

    // ---------------- control and position state
    t_state r_state, n_state;
    logic [MW-1:0] r_clr, n_clr;
    logic r_pend, n_pend;
    logic [EW-1:0] r_px, n_px, r_cl, n_cl, r_crt, n_crt, r_crem, n_crem, r_wq, n_wq, r_wr, n_wr;
    logic [EH-1:0] r_py, n_py, r_cr, n_cr, r_bt, n_bt, r_bb, n_bb, r_rrem, n_rrem;
    logic [EH-1:0] r_hq, n_hq, r_hr, n_hr;
    logic [MW-1:0] r_cc, n_cc;
    logic r_eye, n_eye, r_fg, n_fg, r_fe, n_fe;
    logic [TALLY_W-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_s, n_s;
    logic [7:0] r_val, n_val;
    logic r_ov, n_ov;
    t_out r_out, n_out;

    logic in_acc, dirty, adv, restart;
    logic [EH-1:0] rs_hq, rs_hr;
    logic [EW:0] x1, csum;
    logic [EH:0] y1, rsum;
    logic frame_end, complete;
    logic [TALLY_W-1:0] tnew;
    logic [CW-1:0] colsum;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign dirty      = (r_px != '0) || (r_py != '0);
    assign x1         = {1'b0, r_px} + 1'b1;
    assign y1         = {1'b0, r_py} + 1'b1;
    assign frame_end  = (x1 >= {1'b0, w_eff}) && (y1 >= {1'b0, h_eff});
    assign complete   = (x1 == {1'b0, r_crt}) && (y1 == {1'b0, r_bb});
    assign tnew       = r_rdata + TALLY_W'(r_fg);
    assign colsum     = CW'(r_cc) + (r_eye ? CW'(m_eff) : CW'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
            r_px    <= '0;
            r_py    <= '0;
            r_cc    <= '0;
            r_cr    <= '0;
            r_cl    <= '0;
            r_crt   <= '0;
            r_bt    <= '0;
            r_bb    <= '0;
            r_crem  <= '0;
            r_rrem  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
            r_px    <= n_px;
            r_py    <= n_py;
            r_cc    <= n_cc;
            r_cr    <= n_cr;
            r_cl    <= n_cl;
            r_crt   <= n_crt;
            r_bt    <= n_bt;
            r_bb    <= n_bb;
            r_crem  <= n_crem;
            r_rrem  <= n_rrem;
        end
    end

    // payload and spacing registers: filled before first use
    always_ff @(posedge i_clk) begin
        r_wq  <= n_wq;
        r_wr  <= n_wr;
        r_hq  <= n_hq;
        r_hr  <= n_hr;
        r_eye <= n_eye;
        r_fg  <= n_fg;
        r_fe  <= n_fe;
        r_cnt <= n_cnt;
        r_s   <= n_s;
        r_val <= n_val;
        r_out <= n_out;
    end

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;   n_pend = r_pend;
        n_px = r_px;     n_py = r_py;     n_cc = r_cc;   n_cr = r_cr;
        n_cl = r_cl;     n_crt = r_crt;   n_bt = r_bt;   n_bb = r_bb;
        n_crem = r_crem; n_rrem = r_rrem;
        n_wq = r_wq;     n_wr = r_wr;     n_hq = r_hq;   n_hr = r_hr;
        n_eye = r_eye;   n_fg = r_fg;     n_fe = r_fe;
        n_cnt = r_cnt;   n_s = r_s;       n_val = r_val; n_out = r_out;
        n_ov = (r_ov && !i_out_stall) ? 1'b0 : r_ov;
        mem_we = 1'b0;   mem_re = 1'b0;   mem_addr = r_cc; mem_wdata = '0;
        div_start = 1'b0;
        div_dividend = NW'(w_eff);
        div_divisor  = SW'(m_eff);
        adv = 1'b0;      restart = 1'b0;
        rs_hq = r_hq;    rs_hr = r_hr;
        csum = '0;       rsum = '0;

        case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
                if (r_clr == MW'(MAX_MASK_WIDTH - 1)) begin
                    n_clr   = '0;
                    n_state = r_pend ? S_READ : S_WGO;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_WGO: begin
                div_start = 1'b1;
                n_state   = S_WWAIT;
            end
            S_WWAIT: begin
                if (div_done) begin
                    n_wq    = EW'(div_q);
                    n_wr    = EW'(div_r);
                    n_state = S_HGO;
                end
            end
            S_HGO: begin
                div_start    = 1'b1;
                div_dividend = NW'(h_eff);
                div_divisor  = SW'(n_eff);
                n_state      = S_HWAIT;
            end
            S_HWAIT: begin
                if (div_done) begin
                    n_hq    = EH'(div_q);
                    n_hr    = EH'(div_r);
                    rs_hq   = EH'(div_q);
                    rs_hr   = EH'(div_r);
                    restart = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_eye = i_in_data.eye_select;
                    n_fg  = fg_in;
                    n_state = S_READ;
                    if (i_in_data.frame_start) begin
                        restart = 1'b1;
                        if (dirty) begin
                            n_state = S_CLEAR;
                            n_clr   = '0;
                            n_pend  = 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                mem_re  = 1'b1;
                n_state = S_RMW;
            end
            S_RMW: begin
                mem_we = 1'b1;
                if (complete) begin
                    mem_wdata = '0;
                    n_cnt   = tnew;
                    n_s     = SW'(r_crt - r_cl) * SW'(r_bb - r_bt);
                    n_fe    = frame_end;
                    n_state = S_MUL;
                end else begin
                    mem_wdata = tnew;
                    adv     = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                // cnt*255 + s/2, rounded share numerator
                div_start    = 1'b1;
                div_dividend = NW'({r_cnt, 8'b0}) - NW'(r_cnt) + NW'(r_s >> 1);
                div_divisor  = r_s;
                n_state      = S_RWAIT;
            end
            S_RWAIT: begin
                if (div_done) begin
                    n_val   = div_q[7:0];
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ov || !i_out_stall) begin
                    n_out.mask_value    = r_val;
                    n_out.mask_column   = 11'(colsum);
                    n_out.mask_row      = 11'(r_cr);
                    n_out.last_of_frame = r_fe;
                    n_ov    = 1'b1;
                    adv     = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // step to the next pixel position
        if (adv) begin
            if (frame_end) begin
                restart = 1'b1;
            end else if (x1 >= {1'b0, w_eff}) begin
                n_px   = '0;
                n_cc   = '0;
                n_cl   = '0;
                n_crt  = r_wq;
                n_crem = r_wr;
                n_py   = EH'(y1);
                if (y1 == {1'b0, r_bb}) begin
                    n_bt = r_bb;
                    n_cr = r_cr + 1'b1;
                    rsum = {1'b0, r_rrem} + {1'b0, r_hr};
                    if (rsum >= {1'b0, n_eff}) begin
                        n_rrem = EH'(rsum - {1'b0, n_eff});
                        n_bb   = r_bb + r_hq + 1'b1;
                    end else begin
                        n_rrem = EH'(rsum);
                        n_bb   = r_bb + r_hq;
                    end
                end
            end else begin
                n_px = EW'(x1);
                if (x1 == {1'b0, r_crt}) begin
                    n_cl = r_crt;
                    n_cc = r_cc + 1'b1;
                    csum = {1'b0, r_crem} + {1'b0, r_wr};
                    if (csum >= {1'b0, m_eff}) begin
                        n_crem = EW'(csum - {1'b0, m_eff});
                        n_crt  = r_crt + r_wq + 1'b1;
                    end else begin
                        n_crem = EW'(csum);
                        n_crt  = r_crt + r_wq;
                    end
                end
            end
        end

        if (restart) begin
            n_px = '0;   n_py = '0;   n_cc = '0;   n_cr = '0;
            n_cl = '0;   n_crt = r_wq; n_crem = r_wr;
            n_bt = '0;   n_bb = rs_hq; n_rrem = rs_hr;
        end

        // geometry write: new spacing, tallies cleared
        if (cfg_geom) begin
            n_state = S_CLEAR;
            n_clr   = '0;
            n_pend  = 1'b0;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    `CKBD_ASSERT(a_out_from_emit, $rose(o_out_valid) |-> $past(r_state == S_EMIT),
        "output word appeared outside emit")
    `CKBD_ASSERT(a_accept_leaves_idle, in_acc |=> (r_state != S_IDLE),
        "accepted word did not start work")
    `CKBD_ASSERT(a_geom_clears, cfg_geom |=> (r_state == S_CLEAR),
        "geometry write did not start the clearing pass")

endmodule

/* bench/ckbd_mask_checker.sv */
// Checker for the chroma key box downsample mask: watches the config, pixel
// and mask channels, predicts each mask cell word and compares. Uses ckbd_pkg.
`timescale 1ns / 1ps
module ckbd_mask_checker #(
    parameter int MAX_EYE_W  = ckbd_pkg::MAX_EYE_WIDTH_DEF,
    parameter int MAX_EYE_H  = ckbd_pkg::MAX_EYE_HEIGHT_DEF,
    parameter int MAX_MASK_W = ckbd_pkg::MAX_MASK_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  ckbd_pkg::t_in                   i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  ckbd_pkg::t_out                  i_out_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [ckbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ckbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import ckbd_pkg::*;

    t_out cell_words[$];

    int key_u, key_v, tol;
    int eye_w_reg, eye_h_reg, mask_w_reg, mask_h_reg;
    int fg_count [MAX_MASK_W];
    int px, py, cell_col, cell_row, cell_lo, cell_hi, band_lo, band_hi, col_rem, row_rem;

    function automatic int clampi(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int geo_w();
        return clampi(eye_w_reg, 1, MAX_EYE_W);
    endfunction

    function automatic int geo_h();
        return clampi(eye_h_reg, 1, MAX_EYE_H);
    endfunction

    function automatic int geo_m();
        return clampi(mask_w_reg, 1, (geo_w() < MAX_MASK_W) ? geo_w() : MAX_MASK_W);
    endfunction

    function automatic int geo_n();
        return clampi(mask_h_reg, 1, geo_h());
    endfunction

    task automatic row_restart();
        px       = 0;
        cell_col = 0;
        cell_lo  = 0;
        cell_hi  = geo_w() / geo_m();
        col_rem  = geo_w() % geo_m();
    endtask

    task automatic frame_restart();
        foreach (fg_count[i]) fg_count[i] = 0;
        row_restart();
        py       = 0;
        cell_row = 0;
        band_lo  = 0;
        band_hi  = geo_h() / geo_n();
        row_rem  = geo_h() % geo_n();
    endtask

    task automatic apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_KEY_U:       key_u = data[7:0];
            REG_KEY_V:       key_v = data[7:0];
            REG_TOLERANCE:   tol = data[7:0];
            REG_EYE_WIDTH:   eye_w_reg = data;
            REG_EYE_HEIGHT:  eye_h_reg = data;
            REG_MASK_WIDTH:  mask_w_reg = data[10:0];
            REG_MASK_HEIGHT: mask_h_reg = data;
            default: ;
        endcase
        if (idx >= REG_EYE_WIDTH && idx <= REG_MASK_HEIGHT) frame_restart();
    endtask

    // One pixel: tally, maybe close a cell, then advance the raster position.
    task automatic pixel_step(t_in d);
        int w, h, m, n, du, dv, idx;
        bit fg, last_px;
        longint area, share;
        t_out r;
        w = geo_w();
        h = geo_h();
        m = geo_m();
        n = geo_n();
        du = int'(d.chroma_u) - key_u;
        dv = int'(d.chroma_v) - key_v;
        if (d.frame_start) frame_restart();
        fg = (du * du + dv * dv) > tol * tol;
        idx = cell_col % MAX_MASK_W;
        fg_count[idx] = (fg_count[idx] + int'(fg)) & 32'h7FFFFF;
        last_px = (px + 1 >= w) && (py + 1 >= h);
        if (px + 1 == cell_hi && py + 1 == band_hi) begin
            area = longint'(cell_hi - cell_lo) * longint'(band_hi - band_lo);
            share = 0;
            if (area != 0) share = (longint'(fg_count[idx]) * 255 + area / 2) / area;
            r.mask_value    = share[7:0];
            r.mask_column   = 11'(cell_col + int'(d.eye_select) * m);
            r.mask_row      = 11'(cell_row);
            r.last_of_frame = last_px;
            cell_words.push_back(r);
            fg_count[idx] = 0;
        end
        if (last_px) begin
            frame_restart();
        end else if (px + 1 >= w) begin
            row_restart();
            if (py + 1 == band_hi) begin
                band_lo = band_hi;
                cell_row++;
                band_hi += h / n;
                row_rem += h % n;
                if (row_rem >= n) begin
                    row_rem -= n;
                    band_hi++;
                end
            end
            py++;
        end else begin
            if (px + 1 == cell_hi) begin
                cell_lo = cell_hi;
                cell_col++;
                cell_hi += w / m;
                col_rem += w % m;
                if (col_rem >= m) begin
                    col_rem -= m;
                    cell_hi++;
                end
            end
            px++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            key_u      = RST_KEY_U;
            key_v      = RST_KEY_V;
            tol        = RST_TOLERANCE;
            eye_w_reg  = RST_EYE_WIDTH;
            eye_h_reg  = RST_EYE_HEIGHT;
            mask_w_reg = RST_MASK_WIDTH;
            mask_h_reg = RST_MASK_HEIGHT;
            frame_restart();
            cell_words.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (cell_words.size() == 0) begin
                    $display("%0t: unexpected word %p", $time, i_out_data);
                    o_fail_count++;
                end else begin
                    want = cell_words.pop_front();
                    if (want.mask_value !== i_out_data.mask_value
                        || want.mask_column !== i_out_data.mask_column
                        || want.mask_row !== i_out_data.mask_row
                        || want.last_of_frame !== i_out_data.last_of_frame) begin
                        $display("%0t: expected %p, actual %p", $time, want, i_out_data);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) apply_cfg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !i_in_stall) pixel_step(i_in_data);
        end
        o_pending = cell_words.size();
    end

endmodule

/* bench/chroma_key_box_downsample_mask_tb.sv */
// Testbench top for the chroma key box downsample mask: drives pixel frames,
// config writes and mask stalls; ckbd_mask_checker does the predicting.
`timescale 1ns / 1ps
module chroma_key_box_downsample_mask_tb;
    import ckbd_pkg::*;

    localparam int IDLE_PCT   = 35;
    localparam int DRAIN_WAIT = 100;   // covers the multiply/divide of a closing cell
    localparam int HOLD_LEN   = 500;   // long receiver hold-off
    localparam int DOG_LIMIT  = 20000; // longest quiet spell: clear pass plus hold-off

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out                  o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int words_pending;
    bit calm;       // no idling on either side
    bit hold_req;   // ask the receiver for one long hold-off
    int cur_key_u, cur_key_v, cur_tol;
    int quiet_cycles;

    chroma_key_box_downsample_mask u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    ckbd_mask_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, one counted long hold-off per request.
    always @(posedge i_clk) begin
        int hold_left;
        bit hold_seen;
        if (hold_req && !hold_seen) hold_left = HOLD_LEN;
        hold_seen = hold_req;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog: cycles with no word moving on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= DOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one pixel word; returns once it is taken. Stall only changes at
    // a rising edge, so it is sampled at the falling edge before.
    task automatic send_pixel(t_in d);
        bit stalled;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
    endtask

    // Write registers back to back, then drop valid.
    task automatic write_regs(logic [CFG_IDX_W-1:0] idx[$], int vals[$]);
        bit rdy;
        foreach (idx[k]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= CFG_DATA_W'(vals[k]);
            do begin
                @(negedge i_clk);
                rdy = o_cfg_ready;
                @(posedge i_clk);
            end while (!rdy);
            if (idx[k] == REG_KEY_U) cur_key_u = vals[k] & 8'hFF;
            if (idx[k] == REG_KEY_V) cur_key_v = vals[k] & 8'hFF;
            if (idx[k] == REG_TOLERANCE) cur_tol = vals[k] & 8'hFF;
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_all(int ku, int kv, int tl, int ew, int eh, int mw, int mh);
        write_regs('{REG_KEY_U, REG_KEY_V, REG_TOLERANCE, REG_EYE_WIDTH,
                     REG_EYE_HEIGHT, REG_MASK_WIDTH, REG_MASK_HEIGHT},
                   '{ku, kv, tl, ew, eh, mw, mh});
    endtask

    // Sender pauses until every cell word has come, then the block settles.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_chroma(int key);
        int v;
        if ($urandom_range(1) == 0) return 8'($urandom_range(255));
        v = key + $urandom_range(0, 2 * cur_tol + 16) - cur_tol - 8;
        return 8'((v < 0) ? 0 : ((v > 255) ? 255 : v));
    endfunction

    function automatic t_in mk_pixel(logic [7:0] u, logic [7:0] v, bit eye, bit fs);
        t_in d;
        d.chroma_u    = u;
        d.chroma_v    = v;
        d.eye_select  = eye;
        d.frame_start = fs;
        return d;
    endfunction

    // Mostly whole frames with frame start; some cut short, some left unmarked.
    task automatic send_frames(int w, int h, int budget, bit pause_midway);
        int sent, len, npx;
        bit eye, fs, was_cut;
        sent = 0;
        was_cut = 0;
        npx = w * h;
        while (sent < budget) begin
            len = ($urandom_range(99) < 4) ? $urandom_range(1, npx) : npx;
            fs  = was_cut || ($urandom_range(99) < 80);
            eye = $urandom_range(1);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(99) < 5) eye = !eye;
                send_pixel(mk_pixel(pick_chroma(cur_key_u), pick_chroma(cur_key_v),
                                    eye, (i == 0) && fs));
                sent++;
                if (pause_midway && sent == budget / 2) drain();
            end
            was_cut = (len != npx);
        end
    endtask

    initial begin
        int w, h;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        calm     = 1'b0;
        hold_req = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Each pixel its own cell, zero tolerance: chroma and key extremes.
        set_all(0, 255, 0, 4, 2, 4, 2);
        send_pixel(mk_pixel(8'd0, 8'd255, 1'b0, 1'b1));   // exact key, background
        send_pixel(mk_pixel(8'd255, 8'd0, 1'b1, 1'b0));
        send_pixel(mk_pixel(8'd0, 8'd254, 1'b0, 1'b0));
        send_pixel(mk_pixel(8'd255, 8'd255, 1'b1, 1'b0));
        send_pixel(mk_pixel(8'd0, 8'd0, 1'b1, 1'b0));
        send_pixel(mk_pixel(8'd170, 8'd85, 1'b0, 1'b0));
        send_pixel(mk_pixel(8'd85, 8'd170, 1'b1, 1'b0));
        send_pixel(mk_pixel(8'd1, 8'd255, 1'b0, 1'b0));
        // Frame end without frame start: wraps into a new frame.
        send_pixel(mk_pixel(8'd0, 8'd255, 1'b1, 1'b0));
        drain();
        // Widest tolerance against the farthest chroma; key written alone.
        write_regs('{REG_KEY_U, REG_KEY_V, REG_TOLERANCE}, '{255, 0, 255});
        send_pixel(mk_pixel(8'd0, 8'd255, 1'b0, 1'b0));
        send_pixel(mk_pixel(8'd0, 8'd0, 1'b1, 1'b0));
        // Frame start mid-frame drops the partial frame.
        send_pixel(mk_pixel(8'd0, 8'd255, 1'b1, 1'b1));
        send_pixel(mk_pixel(8'd255, 8'd0, 1'b0, 1'b0));
        drain();
        // Unused register index is ignored.
        write_regs('{3'd7}, '{4095});

        // Geometry below range and above: one pixel wide, 2048 rows of one pixel.
        set_all(128, 128, 10, 0, 4095, 0, 4095);
        for (int i = 0; i < 6; i++)
            send_pixel(mk_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                                1'($urandom_range(1)), 1'b0));
        drain();
        // Widest eye, start of one row: mask clamps to 1024 columns of two pixels.
        set_all(54, 34, 34, 4095, 0, 2047, 0);
        calm = 1'b1;
        for (int i = 0; i < 600; i++)
            send_pixel(mk_pixel(pick_chroma(cur_key_u), pick_chroma(cur_key_v),
                                1'b1, i == 0));
        calm = 1'b0;
        drain();

        // Random geometries, mostly even and small so cells close often.
        for (int ph = 0; ph < 12; ph++) begin
            w = ($urandom_range(99) < 20) ? $urandom_range(2, 25) : 2 * $urandom_range(1, 12);
            h = ($urandom_range(99) < 20) ? $urandom_range(2, 11) : 2 * $urandom_range(1, 5);
            set_all($urandom_range(255), $urandom_range(255),
                    ($urandom_range(9) == 0) ? 255 : $urandom_range(0, 120),
                    w, h, $urandom_range(1, w), $urandom_range(1, h));
            calm = (ph == 3);
            hold_req = (ph == 5);
            send_frames(w, h, 110, ph == 7);
            hold_req = 1'b0;
            drain();
        end
        calm = 1'b0;

        // Final settle: everything already drained, then a short grace period.
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
